// File: rtl/fdes_pkg.sv
// Shared types and constants of the frame difference edge shake detector.
`timescale 1ns / 1ps

package fdes_pkg;

    localparam int OVL_W       = 21;        // overlap and reference count width
    localparam int SIM_W       = 10;        // similarity in tenths of a percent
    localparam int CNT_W       = 4;         // frame index, hit count, window, alarm limit
    localparam int PROD_W      = OVL_W + SIM_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = OVL_W;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;
    localparam int DIV_STEPS   = SIM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int DEF_MAX_FRAME_PIXELS = 1048576;

    // Overlap saturates at the smaller of the frame size and the counter width
    localparam logic [OVL_W-1:0] OVERLAP_CAP =
        (DEF_MAX_FRAME_PIXELS < (2**OVL_W - 1)) ? OVL_W'(DEF_MAX_FRAME_PIXELS) : '1;
    localparam logic [SIM_W-1:0] SIM_MAX     = SIM_W'(999);
    localparam logic [SIM_W-1:0] SCALE       = SIM_W'(1000);

    // Register map of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_EDGE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIM_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HITS     = 3'd4;

    typedef struct packed {
        logic pix_load;     // pixel word accepted
        logic mul_load;     // latch frame-end products
        logic div_init;     // seed the divider
        logic div_step;     // one quotient bit
        logic finish;       // update frame state, load frame result
    } fdes_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a word this cycle
    } fdes_stat_t;

endpackage

// File: rtl/fdes_ctrl.sv
// Controller: accepts pixels and sequences the frame-end computation.
`timescale 1ns / 1ps

module fdes_ctrl
    import fdes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tlast,
    output logic       s_axis_tready,
    input  fdes_stat_t stat,
    output fdes_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              accept;

    assign s_axis_tready = (state_reg == ST_RUN) && stat.out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd          = '0;
        cmd.pix_load = accept;
        cmd.mul_load = (state_reg == ST_MUL);
        cmd.div_init = (state_reg == ST_INIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.finish   = (state_reg == ST_FIN) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_RUN:
                begin
                    if (accept && s_axis_tlast)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_INIT;
                end
                ST_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule

// File: rtl/fdes_datapath.sv
// Datapath: gray difference, overlap count, divider, hit window and output register.
`timescale 1ns / 1ps

module fdes_datapath
    import fdes_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fdes_cmd_t             cmd,
    output fdes_stat_t            stat,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  pix_data,
    input  logic                  pix_edge,
    input  logic                  pix_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    localparam logic [OVL_W-1:0] PIX_CAP =
        (MAX_FRAME_PIXELS < (2**OVL_W - 1)) ? OVL_W'(MAX_FRAME_PIXELS) : '1;

    // Configuration
    logic [7:0]       thr_reg;
    logic [OVL_W-1:0] refc_reg;
    logic [SIM_W-1:0] lim_reg;
    logic [CNT_W-1:0] win_reg;
    logic [CNT_W-1:0] alm_reg;

    // Frame state
    logic [OVL_W-1:0]  overlap_reg;
    logic [OVL_W-1:0]  fov_reg;
    logic              fmot_reg;
    logic [PROD_W-1:0] prod_ov_reg;
    logic [PROD_W-1:0] prod_lim_reg;
    logic [OVL_W-1:0]  rem_reg;
    logic [SIM_W-1:0]  lo_reg;
    logic [SIM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  fidx_reg;
    logic [CNT_W-1:0]  hit_reg;

    // Output register
    logic              out_valid_reg;
    logic              o_motion_reg;
    logic              o_last_reg;
    logic [SIM_W-1:0]  o_sim_reg;
    logic              o_alarm_reg;

    // Gray values: floor(sum/3) as (sum*683)>>11, exact for sums up to 765
    function automatic logic [7:0] gray3(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
        logic [9:0]  s;
        logic [18:0] p;
        s = 10'(b) + 10'(g) + 10'(r);
        p = 19'(s) * 19'(683);
        return p[18:11];
    endfunction

    logic [7:0]       gray_past;
    logic [7:0]       gray_now;
    logic [7:0]       mag;
    logic             motion;
    logic             ovl_inc;
    logic [OVL_W-1:0] ovl_next;

    assign gray_past = gray3(pix_data[7:0], pix_data[15:8], pix_data[23:16]);
    assign gray_now  = gray3(pix_data[31:24], pix_data[39:32], pix_data[47:40]);
    assign mag       = (gray_now >= gray_past) ? (gray_now - gray_past)
                                               : (gray_past - gray_now);
    assign motion    = mag > thr_reg;
    assign ovl_inc   = motion && pix_edge && (overlap_reg < PIX_CAP);
    assign ovl_next  = overlap_reg + OVL_W'(ovl_inc);

    // Restoring divider step
    logic [OVL_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, lo_reg[SIM_W-1]};
    assign fits  = trial >= {1'b0, refc_reg};

    // Frame-end decisions
    logic [SIM_W-1:0] sim;
    logic [CNT_W-1:0] fidx_inc;
    logic             win_clear;
    logic [CNT_W-1:0] hit_win;
    logic [CNT_W-1:0] hit_new;
    logic             alarm;

    always_comb
    begin
        if (refc_reg == '0)
        begin
            sim = (fov_reg != '0) ? SIM_MAX : '0;
        end
        else if (fov_reg >= refc_reg)
        begin
            sim = SIM_MAX;
        end
        else
        begin
            sim = quo_reg;
        end
        fidx_inc  = fidx_reg + 1'b1;
        win_clear = (fidx_inc == win_reg);
        hit_win   = win_clear ? '0 : hit_reg;
        hit_new   = hit_win;
        if ((prod_ov_reg > prod_lim_reg) && (hit_win != '1))
        begin
            hit_new = hit_win + 1'b1;
        end
        alarm = hit_new > alm_reg;
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 8'd30;
            refc_reg      <= '0;
            lim_reg       <= SIM_W'(550);
            win_reg       <= CNT_W'(15);
            alm_reg       <= CNT_W'(4);
            overlap_reg   <= '0;
            fidx_reg      <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DIFF_THRESHOLD: thr_reg  <= cfg_data[7:0];
                    REG_REF_EDGE_COUNT: refc_reg <= cfg_data;
                    REG_SIM_LIMIT:      lim_reg  <= cfg_data[SIM_W-1:0];
                    REG_WINDOW_FRAMES:  win_reg  <= cfg_data[CNT_W-1:0];
                    REG_ALARM_HITS:     alm_reg  <= cfg_data[CNT_W-1:0];
                    default:            ;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.pix_load)
            begin
                if (pix_last)
                begin
                    overlap_reg <= '0;
                end
                else
                begin
                    overlap_reg   <= ovl_next;
                    out_valid_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                fidx_reg      <= win_clear ? '0 : fidx_inc;
                hit_reg       <= alarm ? '0 : hit_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.pix_load)
        begin
            if (pix_last)
            begin
                fov_reg  <= ovl_next;
                fmot_reg <= motion;
            end
            else
            begin
                o_motion_reg <= motion;
                o_last_reg   <= 1'b0;
                o_sim_reg    <= '0;
                o_alarm_reg  <= 1'b0;
            end
        end
        if (cmd.mul_load)
        begin
            prod_ov_reg  <= PROD_W'(fov_reg) * PROD_W'(SCALE);
            prod_lim_reg <= PROD_W'(lim_reg) * PROD_W'(refc_reg);
        end
        if (cmd.div_init)
        begin
            // Only used when overlap < reference, so the quotient fits in 10 bits
            rem_reg <= prod_ov_reg[PROD_W-1:SIM_W];
            lo_reg  <= prod_ov_reg[SIM_W-1:0];
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= fits ? OVL_W'(trial - {1'b0, refc_reg}) : trial[OVL_W-1:0];
            lo_reg  <= {lo_reg[SIM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SIM_W-2:0], fits};
        end
        if (cmd.finish)
        begin
            o_motion_reg <= fmot_reg;
            o_last_reg   <= 1'b1;
            o_sim_reg    <= sim;
            o_alarm_reg  <= alarm;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {4'b0, o_alarm_reg, o_sim_reg, o_motion_reg};

endmodule

// File: rtl/frame_diff_edge_shake_detector_unit.sv
// Top level of the frame difference edge shake detector.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the s_axis channel, one word per pixel: past and current RGB in
// tdata, the dilated reference edge bit in tuser, and tlast on the last pixel of a
// frame. Every pixel yields exactly one word on m_axis: the motion bit, and on the
// frame's last pixel (tlast high) also the similarity in tenths of a percent and the
// alarm bit. Registers are written on the cfg channel (index, data) while the block
// is idle; the block does not enforce this. cfg_ready is always high and unknown
// indexes are ignored. A pixel word is registered and appears in the cycle after
// acceptance. Ordinary pixels are taken one per cycle while m_axis_tready is high.
// The last pixel of a frame starts a sequence (product latch, divider seed, ten
// steps of the bit-serial restoring divider and a final update); the block takes
// no pixel until it ends. When the receiver stalls, the single output register
// holds its word and s_axis_tready drops until that word is taken.
// Reset clears the overlap count, frame index and hit count, and loads the register
// defaults: threshold 30, reference count 0, limit 550, window 15, alarm limit 4.
// MAX_FRAME_PIXELS caps the overlap count.

module frame_diff_edge_shake_detector_unit
    import fdes_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // past_blue, past_green, past_red, now_blue, now_green, now_red
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // ref_edge
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // motion, similarity_tenths[10:1], alarm, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fdes_cmd_t  cmd;
    fdes_stat_t stat;

    assign cfg_ready = 1'b1;

    fdes_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    fdes_datapath #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (s_axis_tdata),
        .pix_edge  (s_axis_tuser),
        .pix_last  (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
